/* design/psd_pkg.sv */
package psd_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int DIST_WIDTH      = 25;

  // radicand of the square root stage: twice the result width plus a guard pair
  localparam int SQRT_RAD_WIDTH  = 2 * DIST_WIDTH + 2;

endpackage

/* design/psd_div.sv */
module psd_div #(
  parameter int NUM_W  = 50,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [NUM_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] out_side
);

  // one quotient bit per stage, restoring division with num < den
  logic              v_s    [Q_W];
  logic [NUM_W-1:0]  r_s    [Q_W];
  logic [NUM_W-1:0]  d_s    [Q_W];
  logic [Q_W-1:0]    q_s    [Q_W];
  logic [SIDE_W-1:0] side_s [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic              src_v;
    logic [NUM_W-1:0]  src_r;
    logic [NUM_W-1:0]  src_d;
    logic [Q_W-1:0]    src_q;
    logic [SIDE_W-1:0] src_side;
    logic [NUM_W:0]    shifted;
    logic [NUM_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_r    = num;
      assign src_d    = den;
      assign src_q    = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_v    = v_s[i-1];
      assign src_r    = r_s[i-1];
      assign src_d    = d_s[i-1];
      assign src_q    = q_s[i-1];
      assign src_side = side_s[i-1];
    end

    assign shifted = {src_r, 1'b0};
    assign ge      = shifted >= {1'b0, src_d};
    assign diff    = shifted - {1'b0, src_d};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i] <= 1'b0;
      end else begin
        v_s[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      r_s[i]    <= ge ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
      d_s[i]    <= src_d;
      q_s[i]    <= {src_q[Q_W-2:0], ge};
      side_s[i] <= src_side;
    end
  end

  assign out_valid = v_s[Q_W-1];
  assign quot      = q_s[Q_W-1];
  assign out_side  = side_s[Q_W-1];

endmodule

/* design/psd_sqrt.sv */
module psd_sqrt #(
  parameter int RAD_W  = 52,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     rad,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   root,
  output logic [RAD_W/2+1:0]   rem,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int STEPS  = RAD_W / 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // one root bit per stage, two radicand bits consumed each time
  logic              v_s    [STEPS];
  logic [RAD_W-1:0]  rad_s  [STEPS];
  logic [ROOT_W-1:0] root_s [STEPS];
  logic [REM_W-1:0]  rem_s  [STEPS];
  logic [SIDE_W-1:0] side_s [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic              src_v;
    logic [RAD_W-1:0]  src_rad;
    logic [ROOT_W-1:0] src_root;
    logic [REM_W-1:0]  src_rem;
    logic [SIDE_W-1:0] src_side;
    logic [REM_W+1:0]  rem2;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_rad  = rad;
      assign src_root = '0;
      assign src_rem  = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_v    = v_s[i-1];
      assign src_rad  = rad_s[i-1];
      assign src_root = root_s[i-1];
      assign src_rem  = rem_s[i-1];
      assign src_side = side_s[i-1];
    end

    assign rem2  = {src_rem, src_rad[RAD_W-1:RAD_W-2]};
    assign trial = {2'b00, src_root, 2'b01};
    assign ge    = rem2 >= trial;
    assign diff  = rem2 - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i] <= 1'b0;
      end else begin
        v_s[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      rad_s[i]  <= {src_rad[RAD_W-3:0], 2'b00};
      root_s[i] <= {src_root[ROOT_W-2:0], ge};
      rem_s[i]  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
      side_s[i] <= src_side;
    end
  end

  assign out_valid = v_s[STEPS-1];
  assign root      = root_s[STEPS-1];
  assign rem       = rem_s[STEPS-1];
  assign out_side  = side_s[STEPS-1];

endmodule

/* design/point_segment_distance.sv */
// Throughput: one request per cycle; busy is never raised.
// The pipeline holds one divider stage per bit of t and one square root stage
// per root bit of the 52-bit radicand (26), plus eight arithmetic stages.
// Reset (synchronous, rst high) clears every valid bit; requests in flight are dropped.
// The receiver cannot stall: each result shows on distance for exactly one cycle with done.
module point_segment_distance #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_start_z,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_z,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                          target_present,
  output logic                          done,
  output logic [psd_pkg::DIST_WIDTH-1:0] distance
);

  localparam int W      = COORD_WIDTH;
  localparam int T      = T_FRAC_BITS;
  localparam int DW     = psd_pkg::DIST_WIDTH;
  localparam int L      = 2 * W + 2;           // squared length
  localparam int DOTW   = 2 * W + 3;           // signed dot product
  localparam int PW     = W + T + 1;           // |seg| * t
  localparam int KW     = W + 2;               // offset from nearest point
  localparam int D2W    = 2 * W + 4;
  localparam int RADW   = psd_pkg::SQRT_RAD_WIDTH;
  localparam int ROOTW  = RADW / 2;
  localparam int CMPW   = (D2W > RADW) ? D2W : RADW;
  localparam int DIVSW  = 3 + 6 * (W + 1);
  localparam int LAT    = 8 + T + RADW / 2;
  localparam logic [CMPW-1:0] SAT_LIM = (CMPW'(1) << (2 * DW)) - (CMPW'(1) << DW);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic signed [W-1:0] st [3];
  logic signed [W-1:0] en [3];
  logic signed [W-1:0] pt [3];

  assign st[0] = seg_start_x;
  assign st[1] = seg_start_y;
  assign st[2] = seg_start_z;
  assign en[0] = seg_end_x;
  assign en[1] = seg_end_y;
  assign en[2] = seg_end_z;
  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  // stage A: differences
  logic              v_a, tp_a;
  logic signed [W:0] seg_a [3];
  logic signed [W:0] rel_a [3];
  // stage B: products
  logic                  v_b, tp_b;
  logic signed [W:0]     seg_b [3];
  logic signed [W:0]     rel_b [3];
  logic signed [2*W+1:0] sq_b  [3];
  logic signed [2*W+1:0] pr_b  [3];
  // stage C: sums
  logic                   v_c, tp_c;
  logic signed [W:0]      seg_c [3];
  logic signed [W:0]      rel_c [3];
  logic [L-1:0]           len2_c;
  logic signed [DOTW-1:0] dot_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
    end else begin
      v_a <= accept;
      v_b <= v_a;
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    tp_a <= target_present;
    tp_b <= tp_a;
    tp_c <= tp_b;
    for (int c = 0; c < 3; c++) begin
      seg_a[c] <= (W+1)'(en[c]) - (W+1)'(st[c]);
      rel_a[c] <= (W+1)'(pt[c]) - (W+1)'(st[c]);
      seg_b[c] <= seg_a[c];
      rel_b[c] <= rel_a[c];
      sq_b[c]  <= seg_a[c] * seg_a[c];
      pr_b[c]  <= rel_a[c] * seg_a[c];
      seg_c[c] <= seg_b[c];
      rel_c[c] <= rel_b[c];
    end
    len2_c <= $unsigned(sq_b[0]) + $unsigned(sq_b[1]) + $unsigned(sq_b[2]);
    dot_c  <= DOTW'(pr_b[0]) + DOTW'(pr_b[1]) + DOTW'(pr_b[2]);
  end

  // classify t: zero for a degenerate segment or a point behind the start,
  // one for a point past the end, otherwise divide
  logic         t_zero, t_one;
  logic [L-1:0] div_num, div_den;
  logic [DIVSW-1:0] div_side_in, div_side_out;
  logic         div_ov;
  logic [T-1:0] div_q;

  assign t_zero  = (len2_c == '0) || (dot_c <= 0);
  assign t_one   = !t_zero && ($unsigned(dot_c) >= DOTW'(len2_c));
  assign div_num = (t_zero || t_one) ? '0 : dot_c[L-1:0];
  assign div_den = t_zero ? L'(1) : len2_c;
  assign div_side_in = {tp_c, t_zero, t_one, seg_c[0], seg_c[1], seg_c[2],
                        rel_c[0], rel_c[1], rel_c[2]};

  psd_div #(
    .NUM_W  (L),
    .Q_W    (T),
    .SIDE_W (DIVSW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_c),
    .num       (div_num),
    .den       (div_den),
    .in_side   (div_side_in),
    .out_valid (div_ov),
    .quot      (div_q),
    .out_side  (div_side_out)
  );

  logic              tp_d, tz_d, to_d;
  logic signed [W:0] seg_d [3];
  logic signed [W:0] rel_d [3];
  logic [T:0]        t_d;

  assign {tp_d, tz_d, to_d, seg_d[0], seg_d[1], seg_d[2],
          rel_d[0], rel_d[1], rel_d[2]} = div_side_out;
  assign t_d = to_d ? ((T+1)'(1) << T) : (tz_d ? '0 : {1'b0, div_q});

  // stage E: projected magnitude, stage F: rounded offset, stage G: squares,
  // stage H: squared distance
  logic              v_e, tp_e;
  logic [PW-1:0]     prod_e [3];
  logic              neg_e  [3];
  logic signed [W:0] rel_e  [3];
  logic              v_f, tp_f;
  logic signed [KW-1:0] k_f [3];
  logic              v_g, tp_g;
  logic signed [2*KW-1:0] ks_g [3];
  logic              v_h, tp_h;
  logic [D2W-1:0]    d2_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
      v_f <= 1'b0;
      v_g <= 1'b0;
      v_h <= 1'b0;
    end else begin
      v_e <= div_ov;
      v_f <= v_e;
      v_g <= v_f;
      v_h <= v_g;
    end
  end

  logic [W:0]      mag_d [3];
  logic [PW-1:0]   rnd_f [3];
  logic [KW-1:0]   pm_f  [3];
  logic signed [KW-1:0] proj_f [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag_d[c]  = seg_d[c][W] ? $unsigned(-seg_d[c]) : $unsigned(seg_d[c]);
      rnd_f[c]  = prod_e[c] + (PW'(1) << (T - 1));
      pm_f[c]   = KW'(rnd_f[c][T +: W]);
      proj_f[c] = neg_e[c] ? -$signed(pm_f[c]) : $signed(pm_f[c]);
    end
  end

  always_ff @(posedge clk) begin
    tp_e <= tp_d;
    tp_f <= tp_e;
    tp_g <= tp_f;
    tp_h <= tp_g;
    for (int c = 0; c < 3; c++) begin
      prod_e[c] <= PW'(mag_d[c][W-1:0]) * PW'(t_d);
      neg_e[c]  <= seg_d[c][W];
      rel_e[c]  <= rel_d[c];
      k_f[c]    <= KW'(rel_e[c]) - proj_f[c];
      ks_g[c]   <= k_f[c] * k_f[c];
    end
    d2_h <= D2W'($unsigned(ks_g[0])) + D2W'($unsigned(ks_g[1]))
          + D2W'($unsigned(ks_g[2]));
  end

  logic            sat_h;
  logic [CMPW-1:0] d2_ext;
  logic            sq_ov, sq_sat;
  logic [ROOTW-1:0] sq_root;
  logic [ROOTW+1:0] sq_rem;

  assign d2_ext = CMPW'(d2_h);
  assign sat_h  = !tp_h || (d2_ext > SAT_LIM);

  psd_sqrt #(
    .RAD_W  (RADW),
    .SIDE_W (1)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_h),
    .rad       (d2_ext[RADW-1:0]),
    .in_side   (sat_h),
    .out_valid (sq_ov),
    .root      (sq_root),
    .rem       (sq_rem),
    .out_side  (sq_sat)
  );

  // round to nearest: step up when the remainder exceeds the floor root
  logic [ROOTW-1:0] rounded;
  assign rounded = ((ROOTW+2)'(sq_root) < sq_rem) ? sq_root + ROOTW'(1) : sq_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_ov;
    end
  end

  always_ff @(posedge clk) begin
    distance <= sq_sat ? '1 : rounded[DW-1:0];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("request lost in pipeline");

  a_absent: assert property (@(posedge clk) disable iff (rst)
    (accept && !target_present) |-> ##LAT (done && (distance == '1)))
    else $error("absent target did not give all-ones");

  a_t_class: assert property (@(posedge clk) disable iff (rst)
    div_ov |-> !(tz_d && to_d))
    else $error("t flagged as both zero and one");

endmodule

/* tb/point_segment_distance_tb.sv */
module point_segment_distance_tb;

  localparam int CW = psd_pkg::COORD_WIDTH_DEF;
  localparam int TF = psd_pkg::T_FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LATENCY = 34 + TF;
  localparam logic [psd_pkg::DIST_WIDTH-1:0] DIST_ALL_ONES = '1;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez, px, py, pz;
    logic                 present;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [psd_pkg::DIST_WIDTH-1:0] distance;
  query_t cur = '0;

  query_t pending_q[$];
  logic [psd_pkg::DIST_WIDTH-1:0] expected_dist_q[$];
  int idle_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  point_segment_distance dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .seg_start_x(cur.sx), .seg_start_y(cur.sy), .seg_start_z(cur.sz),
    .seg_end_x(cur.ex), .seg_end_y(cur.ey), .seg_end_z(cur.ez),
    .point_x(cur.px), .point_y(cur.py), .point_z(cur.pz),
    .target_present(cur.present), .done(done), .distance(distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [127:0] mag128(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [psd_pkg::DIST_WIDTH-1:0] nearest_distance(input query_t q);
    logic signed [127:0] seg[3], rel[3], a[3], b[3], p[3];
    logic signed [127:0] dot, k;
    logic [127:0] len2, d2, r, pm, s, lo, hi, mid;
    logic [63:0] t;
    if (!q.present) return DIST_ALL_ONES;
    a = '{q.sx, q.sy, q.sz};
    b = '{q.ex, q.ey, q.ez};
    p = '{q.px, q.py, q.pz};
    len2 = 0;
    dot = 0;
    for (int c = 0; c < 3; c++) begin
      seg[c] = b[c] - a[c];
      rel[c] = p[c] - a[c];
      len2 += seg[c] * seg[c];
      dot += rel[c] * seg[c];
    end
    t = 0;
    if (len2 != 0 && dot > 0) begin
      r = dot;
      if (r >= len2) t = 64'd1 << TF;
      else t = 64'((r << TF) / len2);
    end
    d2 = 0;
    for (int c = 0; c < 3; c++) begin
      // round the projected offset half away from zero
      pm = (mag128(seg[c]) * t + (128'd1 << (TF - 1))) >> TF;
      k = rel[c] - (seg[c] < 0 ? -$signed(pm) : $signed(pm));
      d2 += mag128(k) * mag128(k);
    end
    lo = 0;
    hi = 128'd1 << 40;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= d2) lo = mid;
      else hi = mid - 1;
    end
    s = lo;
    if (d2 - s * s > s) s = s + 1;
    return s > DIST_ALL_ONES ? DIST_ALL_ONES : s[psd_pkg::DIST_WIDTH-1:0];
  endfunction

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2, 3: return CW'(int'($urandom_range(0, 4000)) - 2000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    q.sx = pick_coord(); q.sy = pick_coord(); q.sz = pick_coord();
    q.ex = pick_coord(); q.ey = pick_coord(); q.ez = pick_coord();
    q.px = pick_coord(); q.py = pick_coord(); q.pz = pick_coord();
    case ($urandom_range(0, 9))
      0: begin q.ex = q.sx; q.ey = q.sy; q.ez = q.sz; end
      1: begin q.px = CW'(q.sx + int'($urandom_range(0, 20)) - 10); q.py = q.sy; end
      default: ;
    endcase
    q.present = ($urandom_range(0, 19) != 0);
    return q;
  endfunction

  // driver: hold start low while idling, otherwise present the next request
  always @(negedge clk) begin
    if (rst || pending_q.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      cur <= pending_q.pop_front();
    end
  end

  // monitor: predict on acceptance, check on done
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy) begin
        expected_dist_q.push_back(nearest_distance(cur));
      end
      if (done) begin
        if (expected_dist_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: distance %0d", distance);
        end else begin
          logic [psd_pkg::DIST_WIDTH-1:0] want;
          want = expected_dist_q.pop_front();
          if (distance !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("distance mismatch: expected %0d got %0d", want, distance);
          end
        end
      end
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic run_phase(input int pct, input int n);
    idle_pct = pct;
    for (int i = 0; i < n; i++) pending_q.push_back(random_query());
    wait (pending_q.size() == 0);
  endtask

  initial begin
    query_t q;
    logic signed [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, absent target, zero length, behind start, beyond end
    q = '{mn, mn, mn, mx, mx, mx, mx, mn, mx, 1'b1}; pending_q.push_back(q);
    q = '{mx, mx, mx, mn, mn, mn, mn, mx, mn, 1'b1}; pending_q.push_back(q);
    q = '{mx, mx, mx, mx, mx, mx, mn, mn, mn, 1'b1}; pending_q.push_back(q);
    q = '{mn, mn, mn, mn, mn, mn, mx, mx, mx, 1'b1}; pending_q.push_back(q);
    q = '{mx, mx, mx, mx, mx, mx, mn, mn, mn, 1'b0}; pending_q.push_back(q);
    q = '0; pending_q.push_back(q);
    q.present = 1'b1; pending_q.push_back(q);
    q = '{0, 0, 0, 0, 0, 0, 100, -200, 300, 1'b1}; pending_q.push_back(q);
    q = '{0, 0, 0, 1000, 0, 0, -500, 300, 0, 1'b1}; pending_q.push_back(q);
    q = '{0, 0, 0, 1000, 0, 0, 1500, 300, 0, 1'b1}; pending_q.push_back(q);
    q = '{0, 0, 0, 1000, 0, 0, 1000, 300, 0, 1'b1}; pending_q.push_back(q);
    q = '{0, 0, 0, 1000, 0, 0, 0, 300, 0, 1'b1}; pending_q.push_back(q);
    q = '{0, 0, 0, 1000, 1000, 0, 333, 700, 5, 1'b1}; pending_q.push_back(q);
    q = '{-5, 7, -9, 3, -3, 11, 1, 1, 1, 1'b1}; pending_q.push_back(q);
    q = '{mn, 0, 0, mx, 0, 0, 0, mx, mx, 1'b1}; pending_q.push_back(q);
    q = '{0, 0, 0, 1, 1, 1, 1, 0, 0, 1'b1}; pending_q.push_back(q);
    wait (pending_q.size() == 0);

    run_phase(0, 400);
    run_phase(48, 400);
    run_phase(0, 350);
    run_phase(17, 400);

    @(negedge clk);
    wait (expected_dist_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/psd_pkg.sv
design/psd_div.sv
design/psd_sqrt.sv
design/point_segment_distance.sv
tb/point_segment_distance_tb.sv
